### hw/rtl/slodt_pkg.sv
package slodt_pkg;

  // Deadline table geometry.
  localparam int unsigned TASK_SLOTS = 1024;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned ADDR_W     = $clog2(TASK_SLOTS);
  // Table word: deadline in the upper bits, valid flag in bit 0.
  localparam int unsigned MEM_W      = 65;

  // Budget validation limits and register reset values; times in nanoseconds.
  localparam logic [63:0] NS_PER_MS       = 64'd1000000;
  localparam logic [63:0] NS_PER_S        = 64'd1000000000;
  localparam logic [63:0] BUDGET_MIN      = 64'd1 * NS_PER_MS;
  localparam logic [63:0] BUDGET_MAX      = 64'd10 * NS_PER_S;
  localparam logic [63:0] DEF_BUDGET_RST  = 64'd100 * NS_PER_MS;
  localparam logic [15:0] MAX_EVENTS_RST  = 16'd1000;
  localparam logic [63:0] RATE_WINDOW_RST = NS_PER_S;

  // Importance limits.
  localparam logic [31:0] IMP_MIN  = 32'd1;
  localparam logic [31:0] IMP_MAX  = 32'd100;
  localparam logic [6:0]  IMP_NONE = 7'd50;
  localparam logic [6:0]  IMP_TOP  = 7'd101;

  // Serial divide by 100, one byte of the dividend per step.
  localparam int unsigned DIV_W     = 72;
  localparam int unsigned DIV_STEPS = DIV_W / 8;
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SH  = 19;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEFAULT_BUDGET = 2'd0;
  localparam logic [1:0] CFG_MAX_EVENTS     = 2'd1;
  localparam logic [1:0] CFG_RATE_WINDOW    = 2'd2;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_STOP    = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LOOK,
    S_FINISH
  } state_t;

endpackage

### hw/rtl/slo_deadline_tracker.sv
// Channel  Dir  Bus                  Contents (lowest bit first)
// s_*      in   tvalid/tready/tdata  task event, kind in tuser
// m_*      out  tvalid/tready/tdata  one result per event, flags in tuser
// cfg_*    in   we/index/wdata       register writes, no read-back
//
// An enqueue result is valid after the budget multiply, the byte-serial divide
// by 100 and the add and store in S_FINISH. A stopping result is valid after the
// table read, the compare in S_LOOK and S_FINISH. The block is ready for the next
// event in the cycle after the result is loaded, and takes no new event before.
// After reset a clearing pass writes every table entry invalid; s_tready stays
// low meanwhile. A stalled result holds the block in its last step until
// m_tready; the next event is taken after that.
module slo_deadline_tracker
  import slodt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // s_tdata: task_slot[9:0], now_ns[73:10], group_id[137:74],
  //          cfg_present[138], cfg_budget_ns[202:139],
  //          cfg_importance[234:203], still_runnable[235], zero fill
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [239:0] s_tdata,
  // s_tuser: command[0]
  input  logic [0:0]   s_tuser,
  // m_tdata: deadline_out[63:0], lateness_ns[127:64], miss_group[191:128],
  //          miss_time[255:192]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,
  // m_tuser: deadline_valid[0], miss_report[1], miss_suppressed[2]
  output logic [2:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  // Input fields.
  logic [SLOT_W-1:0] in_slot;
  logic [63:0]       in_now;
  logic [63:0]       in_group;
  logic              in_present;
  logic [63:0]       in_budget;
  logic [31:0]       in_imp;
  logic              in_runnable;
  cmd_t              in_cmd;

  assign in_slot     = s_tdata[9:0];
  assign in_now      = s_tdata[73:10];
  assign in_group    = s_tdata[137:74];
  assign in_present  = s_tdata[138];
  assign in_budget   = s_tdata[202:139];
  assign in_imp      = s_tdata[234:203];
  assign in_runnable = s_tdata[235];
  assign in_cmd      = cmd_t'(s_tuser[0]);

  // Configuration registers.
  logic [63:0] default_budget;
  logic [15:0] max_events;
  logic [63:0] rate_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_budget <= DEF_BUDGET_RST;
      max_events     <= MAX_EVENTS_RST;
      rate_window    <= RATE_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT_BUDGET: default_budget <= cfg_wdata;
        CFG_MAX_EVENTS:     max_events     <= cfg_wdata[15:0];
        CFG_RATE_WINDOW:    rate_window    <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // Control state.
  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [3:0]        step;
  logic              accept;
  logic              out_load;

  // Captured event.
  cmd_t              cmd;
  logic [ADDR_W-1:0] slot;
  logic              in_range;
  logic [63:0]       now;
  logic [63:0]       group;
  logic              runnable;
  logic [63:0]       budget;
  logic [6:0]        scale;

  // Work registers.
  logic [DIV_W-1:0]  div;
  logic [6:0]        rem;
  logic              hit;
  logic              miss;
  logic              roll;
  logic [63:0]       lateness;

  // Rate limiter state.
  logic [63:0]       win_base;
  logic [15:0]       window_count;

  // Deadline table.
  logic [MEM_W-1:0]  mem [TASK_SLOTS];
  logic [MEM_W-1:0]  rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(TASK_SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = (in_cmd == CMD_STOP) ? S_LOOK : S_MUL;
      end
      S_MUL:  state_next = S_DIV;
      S_DIV: begin
        if (step == 4'(DIV_STEPS - 1)) state_next = S_FINISH;
      end
      S_LOOK: state_next = S_FINISH;
      S_FINISH: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready = (state == S_IDLE);
    out_load = (state == S_FINISH) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // Budget selection and importance clamp on the incoming event.
  logic       cfg_ok;
  logic [6:0] imp_sel;
  logic [63:0] budget_sel;

  always_comb begin
    cfg_ok = (in_budget >= BUDGET_MIN) && (in_budget <= BUDGET_MAX) &&
             (in_imp >= IMP_MIN) && (in_imp <= IMP_MAX);
    budget_sel = (in_present && cfg_ok) ? in_budget : default_budget;
    if (!in_present) begin
      imp_sel = IMP_NONE;
    end else if (in_imp < IMP_MIN) begin
      imp_sel = IMP_MIN[6:0];
    end else if (in_imp > IMP_MAX) begin
      imp_sel = IMP_MAX[6:0];
    end else begin
      imp_sel = in_imp[6:0];
    end
  end

  // Capture the event at its transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= in_cmd;
      slot     <= ADDR_W'(in_slot);
      in_range <= (32'(in_slot) < TASK_SLOTS);
      now      <= in_now;
      group    <= in_group;
      runnable <= in_runnable;
      budget   <= budget_sel;
      scale    <= IMP_TOP - imp_sel;
    end
  end

  // One quotient byte per step: x < 25600, so the reciprocal is exact.
  logic [14:0] dx;
  logic [27:0] dprod;
  logic [7:0]  dq;
  logic [14:0] dq100;

  always_comb begin
    dx    = {rem, div[DIV_W-1 -: 8]};
    dprod = 28'(dx) * 28'(RECIP_100);
    dq    = dprod[RECIP_SH +: 8];
    dq100 = (15'(dq) << 6) + (15'(dq) << 5) + (15'(dq) << 2);
  end

  // Multiply then divide by 100; the quotient shifts in from the bottom.
  always_ff @(posedge clk) begin
    case (state)
      S_MUL: begin
        div  <= DIV_W'(budget * 71'(scale));
        rem  <= '0;
        step <= '0;
      end
      S_DIV: begin
        div  <= {div[DIV_W-9:0], dq};
        rem  <= 7'(dx - dq100);
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  // Stopping: compare against the stored deadline and check the window.
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      hit      <= in_range && rdata[0];
      miss     <= in_range && rdata[0] && (now > rdata[MEM_W-1:1]);
      lateness <= now - rdata[MEM_W-1:1];
      roll     <= (now - win_base) > rate_window;
    end
  end

  // Saturating deadline sum.
  logic [64:0] dl_sum;
  logic [63:0] deadline;

  always_comb begin
    dl_sum   = {1'b0, now} + {1'b0, div[63:0]};
    deadline = dl_sum[64] ? '1 : dl_sum[63:0];
  end

  // Rate limiter decision.
  logic [15:0] count_eff;
  logic        blocked;

  always_comb begin
    count_eff = roll ? '0 : window_count;
    blocked   = (count_eff >= max_events);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_base     <= '0;
      window_count <= '0;
    end else if (out_load && cmd == CMD_STOP && miss) begin
      if (roll) win_base <= now;
      window_count <= blocked ? count_eff : count_eff + 1'b1;
    end
  end

  // Table write: clearing pass, new deadline, or entry drop.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = {deadline, 1'b1};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (out_load) begin
      if (cmd == CMD_ENQUEUE) begin
        mem_we = in_range;
      end else begin
        mem_we    = hit && !runnable;
        mem_wdata = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[ADDR_W'(in_slot)];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd == CMD_ENQUEUE) begin
        m_tuser <= 3'b001;
        m_tdata <= {192'd0, deadline};
      end else if (miss) begin
        m_tuser <= {blocked, !blocked, 1'b0};
        m_tdata <= {now, group, lateness, 64'd0};
      end else begin
        m_tuser <= '0;
        m_tdata <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  // No event is taken while the table is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("event taken during clearing pass");

  // A result carries at most one of its three flags.
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser))
    else $error("result flags overlap");

  // A transfer starts work, so the next event waits.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("block ready right after a transfer");

  // The table is written only by the clearing pass or a finishing event.
  a_write_when: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_FINISH))
    else $error("table written outside clear or finish");

  // A loaded result is held until the sink takes it.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("pending result lost");
`endif

endmodule
